### sv/ple_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

    // list depth and derived widths
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int DATA_W   = 32;

    // command codes
    localparam logic [2:0] CMD_APPEND  = 3'd0;
    localparam logic [2:0] CMD_INSERT  = 3'd1;
    localparam logic [2:0] CMD_REPLACE = 3'd2;
    localparam logic [2:0] CMD_READ    = 3'd3;
    localparam logic [2:0] CMD_DELETE  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // cell operation kinds broadcast along the chain
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_INSERT = 2'd2;
    localparam logic [1:0] KIND_DELETE = 2'd3;

    typedef struct packed {
        logic [2:0]               command;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } ple_req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] read_value;
        logic [4:0]               entry_count;
    } ple_rsp_t;

    // control broadcast to every cell
    typedef struct packed {
        logic [1:0]        kind;
        logic [CMP_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } ple_ctl_t;

endpackage

`default_nettype wire

### sv/ple_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ple_cell (
    input  wire logic                        clk,
    input  wire logic [ple_pkg::CMP_W-1:0]   index,
    input  wire ple_pkg::ple_ctl_t           ctl,
    input  wire logic [ple_pkg::DATA_W-1:0]  lower_data,
    input  wire logic [ple_pkg::DATA_W-1:0]  upper_data,
    output logic [ple_pkg::DATA_W-1:0]       data
);
    import ple_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              at_pos;
    logic              above_pos;

    assign at_pos    = (index == ctl.pos);
    assign above_pos = (index > ctl.pos);

    // pick own entry, new word or a neighbor's entry
    always_comb
    begin
        data_next = data_reg;
        unique case (ctl.kind)
            KIND_NONE:
            begin
                data_next = data_reg;
            end
            KIND_WRITE:
            begin
                if (at_pos)
                begin
                    data_next = ctl.value;
                end
            end
            KIND_INSERT:
            begin
                if (at_pos)
                begin
                    data_next = ctl.value;
                end
                else if (above_pos)
                begin
                    data_next = lower_data;
                end
            end
            KIND_DELETE:
            begin
                if (at_pos || above_pos)
                begin
                    data_next = upper_data;
                end
            end
        endcase
    end

    // entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

### sv/positional_list_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Positional list engine: an ordered list of up to CAPACITY 32-bit words.
// Command channel: present a request (command, position, value) with start
// high; it is taken at any rising edge where start is high and busy is low.
// busy never rises, so a new command may be issued every cycle.
// Result channel: in the cycle after a command is taken, done pulses for one
// cycle with status, read_value and entry_count on result. The receiver
// cannot stall; it must capture the result in that cycle.
// Throughput is one command per cycle: each entry lives in a cell of a
// chain, and insert or delete moves every later entry to its neighbor cell
// in the same cycle; a read picks one cell by position.
// Status: ok, position out of range, or list full (position checked first).
// Unknown commands change nothing and report ok.
// Reset clears the entry count and the result strobe; entry contents are
// left as they are and only read once written.
module positional_list_engine_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire ple_pkg::ple_req_t request,
    output logic                   done,
    output ple_pkg::ple_rsp_t      result
);
    import ple_pkg::*;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              done_reg;
    ple_rsp_t          result_reg;
    ple_rsp_t          result_next;
    ple_ctl_t          ctl;
    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] read_word;
    logic              accept;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic              full;
    logic              pos_in_list;
    logic              pos_le_count;

    // one command per cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign pos_ext      = CMP_W'(request.position);
    assign cnt_ext      = CMP_W'(count_reg);
    assign full         = (count_reg == CNT_W'(CAPACITY));
    assign pos_in_list  = (pos_ext < cnt_ext);
    assign pos_le_count = (pos_ext <= cnt_ext);

    // read mux over the cells
    always_comb
    begin
        read_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (pos_ext == CMP_W'(i))
            begin
                read_word = cell_data[i];
            end
        end
    end

    // command decode: status, count update and cell control
    always_comb
    begin
        ctl.kind               = KIND_NONE;
        ctl.pos                = pos_ext;
        ctl.value              = request.value;
        count_next             = count_reg;
        result_next.status     = ST_OK;
        result_next.read_value = '0;
        unique case (request.command)
            CMD_APPEND:
            begin
                if (full)
                begin
                    result_next.status = ST_FULL;
                end
                else
                begin
                    ctl.kind   = KIND_WRITE;
                    ctl.pos    = cnt_ext;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_INSERT:
            begin
                if (!pos_le_count)
                begin
                    result_next.status = ST_BAD_POS;
                end
                else if (full)
                begin
                    result_next.status = ST_FULL;
                end
                else
                begin
                    ctl.kind   = KIND_INSERT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_REPLACE:
            begin
                if (!pos_in_list)
                begin
                    result_next.status = ST_BAD_POS;
                end
                else
                begin
                    ctl.kind = KIND_WRITE;
                end
            end
            CMD_READ:
            begin
                if (!pos_in_list)
                begin
                    result_next.status = ST_BAD_POS;
                end
                else
                begin
                    result_next.read_value = read_word;
                end
            end
            CMD_DELETE:
            begin
                if (!pos_in_list)
                begin
                    result_next.status = ST_BAD_POS;
                end
                else
                begin
                    ctl.kind   = KIND_DELETE;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                ctl.kind = KIND_NONE;
            end
        endcase
        if (!accept)
        begin
            ctl.kind   = KIND_NONE;
            count_next = count_reg;
        end
        result_next.entry_count = 5'(count_next);
    end

    // chain of cells, each handing its entry to both neighbors
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_W-1:0] lower;
        logic [DATA_W-1:0] upper;

        if (g == 0)
        begin : g_first
            assign lower = '0;
        end
        else
        begin : g_mid_lo
            assign lower = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign upper = '0;
        end
        else
        begin : g_mid_hi
            assign upper = cell_data[g+1];
        end

        ple_cell u_cell (
            .clk        (clk),
            .index      (CMP_W'(g)),
            .ctl        (ctl),
            .lower_data (lower),
            .upper_data (upper),
            .data       (cell_data[g])
        );
    end

    // count and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### tb/sv/positional_list_engine_core_tb.sv
`timescale 1ns / 1ps

module positional_list_engine_core_tb;

    import ple_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 130;

    // fill, drain and mixed bursts for the random part
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    ple_req_t request;
    logic     done;
    ple_rsp_t result;

    // stimulus not yet presented and results still owed by the block
    ple_req_t cmd_queue[$];
    ple_rsp_t due_results[$];

    // own copy of the list contents and length
    logic [DATA_W-1:0] model_words[CAPACITY];
    int                model_len;

    // length as the stimulus generator sees it, to aim positions
    int gen_len;

    int  sender_idle_pct;
    bit  took;
    int  error_count;
    int  cycle_count;
    int  commands_taken;
    int  ok_seen;
    int  bad_pos_seen;
    int  full_seen;
    int  peak_len;

    positional_list_engine_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // one line per mismatch
    task automatic report_mismatch(input string what, input longint want, input longint got);
        error_count++;
        $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    // apply one command to the list copy and give the result it should cause
    function automatic ple_rsp_t apply_list_command(input ple_req_t req);
        ple_rsp_t rsp;
        int       pos;
        rsp = '0;
        pos = req.position;
        case (req.command)
            CMD_APPEND:
            begin
                if (model_len >= CAPACITY)
                    rsp.status = ST_FULL;
                else
                begin
                    model_words[model_len] = req.value;
                    model_len++;
                end
            end
            CMD_INSERT:
            begin
                if (pos > model_len)
                    rsp.status = ST_BAD_POS;
                else if (model_len >= CAPACITY)
                    rsp.status = ST_FULL;
                else
                begin
                    for (int i = model_len; i > pos; i--)
                        model_words[i] = model_words[i - 1];
                    model_words[pos] = req.value;
                    model_len++;
                end
            end
            CMD_REPLACE:
            begin
                if (pos >= model_len)
                    rsp.status = ST_BAD_POS;
                else
                    model_words[pos] = req.value;
            end
            CMD_READ:
            begin
                if (pos >= model_len)
                    rsp.status = ST_BAD_POS;
                else
                    rsp.read_value = model_words[pos];
            end
            CMD_DELETE:
            begin
                if (pos >= model_len)
                    rsp.status = ST_BAD_POS;
                else
                begin
                    for (int i = pos; i + 1 < model_len; i++)
                        model_words[i] = model_words[i + 1];
                    model_len--;
                end
            end
            default:
            begin
            end
        endcase
        rsp.entry_count = model_len[4:0];
        return rsp;
    endfunction

    // queue one command and track the length it leads to
    task automatic queue_command(input logic [2:0] cmd, input int pos, input logic [31:0] val);
        ple_req_t req;
        req.command  = cmd;
        req.position = pos[POS_W-1:0];
        req.value    = val;
        cmd_queue.push_back(req);
        case (cmd)
            CMD_APPEND:
                if (gen_len < CAPACITY)
                    gen_len++;
            CMD_INSERT:
                if (req.position <= gen_len && gen_len < CAPACITY)
                    gen_len++;
            CMD_DELETE:
                if (req.position < gen_len)
                    gen_len--;
            default:
            begin
            end
        endcase
    endtask

    // a burst of random commands weighted toward filling, draining or neither
    task automatic queue_random_burst(input int n, input int mode);
        int          r;
        int          pos;
        logic [2:0]  cmd;
        logic [31:0] val;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            case (mode)
                MODE_FILL:
                    cmd = (r < 45) ? CMD_APPEND : (r < 80) ? CMD_INSERT :
                          (r < 88) ? CMD_READ : (r < 94) ? CMD_REPLACE :
                          (r < 98) ? CMD_DELETE : 3'($urandom_range(5, 7));
                MODE_DRAIN:
                    cmd = (r < 50) ? CMD_DELETE : (r < 65) ? CMD_READ :
                          (r < 78) ? CMD_REPLACE : (r < 85) ? CMD_INSERT :
                          (r < 92) ? CMD_APPEND : 3'($urandom_range(5, 7));
                default:
                    cmd = (r < 19) ? CMD_APPEND : (r < 38) ? CMD_INSERT :
                          (r < 57) ? CMD_REPLACE : (r < 76) ? CMD_READ :
                          (r < 94) ? CMD_DELETE : 3'($urandom_range(5, 7));
            endcase

            // mostly valid positions, some at the boundary, some anywhere
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                if (cmd == CMD_INSERT)
                    pos = $urandom_range(0, gen_len);
                else
                    pos = (gen_len == 0) ? 0 : $urandom_range(0, gen_len - 1);
            end
            else if (r < 82)
                pos = gen_len;
            else if (r < 88)
                pos = 0;
            else
                pos = $urandom_range(0, 31);

            r = $urandom_range(0, 99);
            case (r % 4)
                0: val = 32'h8000_0000;
                1: val = 32'h7fff_ffff;
                2: val = 32'h0000_0000;
                default: val = 32'hffff_ffff;
            endcase
            if (r >= 10)
                val = $urandom;
            queue_command(cmd, pos, val);
        end
    endtask

    // wait until every queued command was taken and answered
    task automatic wait_for_drain();
        while (cmd_queue.size() != 0 || start || due_results.size() != 0)
            @(posedge clk);
    endtask

    // random phase with a given sender idle share
    task automatic run_random_phase(input int idle_pct);
        int queued;
        int n;
        sender_idle_pct = idle_pct;
        queued = 0;
        while (queued < RANDOM_ITEMS)
        begin
            n = $urandom_range(6, 24);
            queue_random_burst(n, $urandom_range(MODE_FILL, MODE_MIXED));
            queued += n;
        end
        wait_for_drain();
    endtask

    // driver: present the next transaction on the falling edge
    always @(negedge clk)
    begin : driver
        bit       present;
        ple_req_t next_req;
        present  = start && !took;
        next_req = request;
        if (rst_n && (!start || took))
        begin
            present = 1'b0;
            if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                next_req = cmd_queue.pop_front();
                present  = 1'b1;
            end
        end
        start   <= present;
        request <= next_req;
    end

    // monitor: take transactions and check results on the rising edge
    always @(posedge clk)
    begin : monitor
        ple_rsp_t want;
        ple_rsp_t got;
        took <= rst_n && start && !busy;
        if (rst_n)
        begin
            if (done)
            begin
                got = result;
                if (due_results.size() == 0)
                    report_mismatch("unexpected result", 0, got);
                else
                begin
                    want = due_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", want.status, got.status);
                    if (got.read_value !== want.read_value)
                        report_mismatch("read_value", want.read_value, got.read_value);
                    if (got.entry_count !== want.entry_count)
                        report_mismatch("entry_count", want.entry_count, got.entry_count);
                end
            end
            if (start && !busy)
            begin
                want = apply_list_command(request);
                due_results.push_back(want);
                commands_taken++;
                case (want.status)
                    ST_OK:      ok_seen++;
                    ST_BAD_POS: bad_pos_seen++;
                    default:    full_seen++;
                endcase
                if (model_len > peak_len)
                    peak_len = model_len;
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, due_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        request         = '0;
        took            = 1'b0;
        sender_idle_pct = 0;
        error_count     = 0;
        cycle_count     = 0;
        commands_taken  = 0;
        ok_seen         = 0;
        bad_pos_seen    = 0;
        full_seen       = 0;
        peak_len        = 0;
        model_len       = 0;
        gen_len         = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty list: each position below is out of range
        queue_command(CMD_READ, 0, 32'h0);
        queue_command(CMD_DELETE, 0, 32'h0);
        queue_command(CMD_INSERT, 1, 32'h1234_5678);
        // build a short list with extreme words, insert at the end
        queue_command(CMD_INSERT, 0, 32'h8000_0000);
        queue_command(CMD_APPEND, 0, 32'h7fff_ffff);
        queue_command(CMD_INSERT, 2, 32'hffff_ffff);
        queue_command(CMD_REPLACE, 1, 32'h0);
        queue_command(CMD_READ, 0, 32'hffff_ffff);
        queue_command(CMD_READ, 1, 32'h0);
        queue_command(CMD_READ, 2, 32'h0);
        // position equal to the count
        queue_command(CMD_READ, 3, 32'h0);
        queue_command(CMD_REPLACE, 3, 32'h5555_aaaa);
        queue_command(CMD_DELETE, 3, 32'h0);
        // unknown command with all other bits set
        queue_command(3'd7, 31, 32'hffff_ffff);
        queue_command(CMD_DELETE, 1, 32'h0);
        // fill up, then hit the full cases
        while (gen_len < CAPACITY)
            queue_command(CMD_APPEND, 0, $urandom);
        queue_command(CMD_APPEND, 0, 32'hdead_beef);
        queue_command(CMD_INSERT, 17, 32'h1);
        queue_command(CMD_INSERT, 16, 32'h2);
        queue_command(CMD_READ, 15, 32'h0);
        wait_for_drain();

        run_random_phase(0);
        run_random_phase(50);
        run_random_phase(26);
        run_random_phase(0);

        repeat (5) @(posedge clk);
        $display("ran %0d commands: %0d ok, %0d bad position, %0d full, longest list %0d",
                 commands_taken, ok_seen, bad_pos_seen, full_seen, peak_len);
        $display("sender idle shares 0, 50 and 26 percent, with drained pauses between phases");
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
